### hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants shared by the JSON string unescaper modules.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // One input transfer: a raw byte of the escaped string.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // One output transfer.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] error_code;
    logic       run_last;
    logic       string_end;
  } out_item_t;

  // Parser modes.
  localparam logic [2:0] MODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_ESCAPE  = 3'd1;
  localparam logic [2:0] MODE_HEX1    = 3'd2;
  localparam logic [2:0] MODE_HEX2    = 3'd3;
  localparam logic [2:0] MODE_HEX3    = 3'd4;
  localparam logic [2:0] MODE_HEX4    = 3'd5;
  localparam logic [2:0] MODE_DISCARD = 3'd6;

  // Error codes.
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_LETTER = 2'd1;
  localparam logic [1:0] ERR_HEX    = 2'd2;
  localparam logic [1:0] ERR_END    = 2'd3;

  // Characters of interest.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  localparam int unsigned AccW = 12;  // three hex digits held before the fourth

  // Decoder result for one input byte.
  typedef struct packed {
    logic [1:0]           num;       // number of results, 0 to 3
    out_item_t [2:0]      res;       // res[0] is delivered first
    logic [2:0]           mode_nxt;
    logic [AccW-1:0]      acc_nxt;
  } dec_t;

endpackage

### hdl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Decodes one escaped byte against the parser state into up to three results.
// ----------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; (
  input  logic [2:0]      mode_i,
  input  logic [AccW-1:0] acc_i,
  input  in_item_t        item_i,
  output dec_t            dec_o
);

  logic [7:0]  c;
  logic        last;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp;

  assign c    = item_i.in_byte;
  assign last = item_i.in_last;
  assign cp   = {acc_i, hex_val};

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_val = 4'(c - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Single-result helpers.
  function automatic out_item_t byte_res(logic [7:0] b, logic l);
    out_item_t r;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    r.error_code = ERR_NONE;
    r.run_last   = 1'b1;
    r.string_end = l;
    return r;
  endfunction

  function automatic out_item_t err_res(logic [1:0] e, logic l);
    out_item_t r;
    r.out_byte   = 8'h00;
    r.byte_valid = 1'b0;
    r.error_code = e;
    r.run_last   = 1'b1;
    r.string_end = l;
    return r;
  endfunction

  function automatic out_item_t mid_res(logic [7:0] b);
    out_item_t r;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    r.error_code = ERR_NONE;
    r.run_last   = 1'b0;
    r.string_end = 1'b0;
    return r;
  endfunction

  always_comb begin
    dec_o.num      = 2'd0;
    dec_o.res      = '0;
    dec_o.mode_nxt = MODE_NORMAL;
    dec_o.acc_nxt  = '0;

    unique case (mode_i) inside
      MODE_NORMAL: begin
        if (c == CH_BSLASH) begin
          if (last) begin
            dec_o.num    = 2'd1;
            dec_o.res[0] = err_res(ERR_END, last);
          end else begin
            dec_o.mode_nxt = MODE_ESCAPE;
          end
        end else begin
          dec_o.num    = 2'd1;
          dec_o.res[0] = byte_res(c, last);
        end
      end

      MODE_ESCAPE: begin
        dec_o.num = 2'd1;
        unique case (c)
          CH_QUOTE:  dec_o.res[0] = byte_res(CH_QUOTE, last);
          CH_BSLASH: dec_o.res[0] = byte_res(CH_BSLASH, last);
          CH_SLASH:  dec_o.res[0] = byte_res(CH_SLASH, last);
          CH_B:      dec_o.res[0] = byte_res(CTL_BS, last);
          CH_F:      dec_o.res[0] = byte_res(CTL_FF, last);
          CH_N:      dec_o.res[0] = byte_res(CTL_LF, last);
          CH_R:      dec_o.res[0] = byte_res(CTL_CR, last);
          CH_T:      dec_o.res[0] = byte_res(CTL_HT, last);
          CH_U: begin
            if (last) begin
              dec_o.res[0] = err_res(ERR_END, last);
            end else begin
              dec_o.num      = 2'd0;
              dec_o.mode_nxt = MODE_HEX1;
            end
          end
          default: begin
            dec_o.res[0] = err_res(ERR_LETTER, last);
            dec_o.mode_nxt = last ? MODE_NORMAL : MODE_DISCARD;
          end
        endcase
      end

      MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        if (!hex_ok) begin
          dec_o.num      = 2'd1;
          dec_o.res[0]   = err_res(ERR_HEX, last);
          dec_o.mode_nxt = last ? MODE_NORMAL : MODE_DISCARD;
        end else if (last) begin
          dec_o.num    = 2'd1;
          dec_o.res[0] = err_res(ERR_END, last);
        end else begin
          dec_o.mode_nxt = mode_i + 3'd1;
          dec_o.acc_nxt  = cp[AccW-1:0];
        end
      end

      MODE_HEX4: begin
        if (!hex_ok) begin
          dec_o.num      = 2'd1;
          dec_o.res[0]   = err_res(ERR_HEX, last);
          dec_o.mode_nxt = last ? MODE_NORMAL : MODE_DISCARD;
        end else if (cp[15:7] == '0) begin
          dec_o.num    = 2'd1;
          dec_o.res[0] = byte_res({1'b0, cp[6:0]}, last);
        end else if (cp[15:11] == '0) begin
          dec_o.num    = 2'd2;
          dec_o.res[0] = mid_res({3'b110, cp[10:6]});
          dec_o.res[1] = byte_res({2'b10, cp[5:0]}, last);
        end else begin
          dec_o.num    = 2'd3;
          dec_o.res[0] = mid_res({4'b1110, cp[15:12]});
          dec_o.res[1] = mid_res({2'b10, cp[11:6]});
          dec_o.res[2] = byte_res({2'b10, cp[5:0]}, last);
        end
      end

      default: begin
        // Discard mode, and the unused code, drop bytes up to and including the final one.
        dec_o.mode_nxt = last ? MODE_NORMAL : MODE_DISCARD;
      end
    endcase
  end

endmodule

### hdl/json_string_unescape_utf8_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// Unescapes a JSON string byte stream and encodes \u escapes as UTF-8.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Payload
//   in       sink       in_valid_i / in_stall_o  in_data_i  (in_item_t)
//   out      source     out_valid_o / out_stall_i out_data_o (out_item_t)
//
// A byte is decoded in the cycle it is accepted; its up to three results are
// written into a three-entry result register, so its first result appears in
// the cycle after its transfer in. A single-result byte is accepted every
// cycle, and the register drains one entry per cycle, while the output is
// not stalled; a byte with a longer burst holds the input until it drains.
// Reset puts the parser in normal text mode and empties the result register.
// The input is stalled whenever the register cannot take a full burst at once.
//
module json_string_unescape_utf8_core import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // Parser state.
  logic [2:0]      mode_q, mode_d;
  logic [AccW-1:0] acc_q, acc_d;

  // Result register: entry 0 is at the output, later ones shift down.
  out_item_t [2:0] res_q, res_d;
  logic [1:0]      cnt_q, cnt_d;

  dec_t dec;
  logic pop;
  logic room;
  logic take;

  jsu_decode u_decode (
    .mode_i (mode_q),
    .acc_i  (acc_q),
    .item_i (in_data_i),
    .dec_o  (dec)
  );

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = res_q[0];
  assign pop         = out_valid_o && !out_stall_i;

  // A new byte may enter once the register is empty by the end of this cycle.
  assign room       = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign in_stall_o = !room;
  assign take       = in_valid_i && room;

  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    if (pop) begin
      res_d[0] = res_q[1];
      res_d[1] = res_q[2];
      cnt_d    = cnt_q - 2'd1;
    end
    if (take) begin
      mode_d = dec.mode_nxt;
      acc_d  = dec.acc_nxt;
      res_d  = dec.res;
      cnt_d  = dec.num;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      acc_q  <= '0;
      cnt_q  <= 2'd0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

  // Result payload carries no reset.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

### tb/json_string_unescape_utf8_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core_tb
// Self-checking bench for the JSON string unescaper. Escaped strings are
// pushed through the input channel under several idle/stall profiles. A
// shadow decoder predicts the UTF-8 bytes and error results for every
// accepted input transfer, and every output transfer is checked against it.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core_tb;
  import jsu_pkg::*;

  // Run bounds. The slowest legal run is a few hundred transfers, each with
  // up to three results behind an 86 percent receiver stall, so this limit
  // leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned MAX_PRINTS  = 20;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  in_item_t  in_data     = '0;
  logic      out_stall   = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  // The eight escape letters that map to a single byte.
  logic [7:0] simple_esc [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                 CH_F, CH_N, CH_R, CH_T};

  // Stimulus and prediction stores.
  in_item_t   escaped_in_q    [$];  // input transfers waiting to be offered
  logic [7:0] string_buf      [$];  // string under construction
  out_item_t  utf8_expected_q [$];  // predicted results, oldest first

  // Shadow copy of the parser state.
  logic [2:0]  shadow_mode = MODE_NORMAL;
  logic [15:0] shadow_acc  = '0;

  // Traffic profile, changed only between phases; hold_count counts the hold.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_armed     = 1'b0;
  int unsigned hold_count     = 0;

  // Bookkeeping.
  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned error_results  = 0;
  int unsigned strings_closed = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  out_item_t   oldest_want;

  json_string_unescape_utf8_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow decoder
  // --------------------------------------------------------------------------

  // Returns {1, value} for a hex digit in either case, zero otherwise.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    return 5'd0;
  endfunction

  task automatic expect_result(input logic [7:0] b, input logic v, input logic [1:0] e,
                               input logic rl, input logic se);
    out_item_t r;
    r.out_byte   = b;
    r.byte_valid = v;
    r.error_code = e;
    r.run_last   = rl;
    r.string_end = se;
    utf8_expected_q.push_back(r);
  endtask

  // An error gives one empty result. Unless it fell on the final byte, the
  // rest of the string is thrown away.
  task automatic raise_error(input logic [1:0] code, input logic lst);
    expect_result(8'h00, 1'b0, code, 1'b1, lst);
    shadow_mode = lst ? MODE_NORMAL : MODE_DISCARD;
    shadow_acc  = '0;
  endtask

  task automatic emit_plain(input logic [7:0] b, input logic lst);
    expect_result(b, 1'b1, ERR_NONE, 1'b1, lst);
    shadow_mode = MODE_NORMAL;
    shadow_acc  = '0;
  endtask

  // Works out the results of one accepted input transfer and advances the
  // shadow state.
  task automatic decode_escaped_byte(input in_item_t it);
    logic [7:0]  c;
    logic        lst;
    logic [4:0]  hv;
    logic [15:0] cp;
    c   = it.in_byte;
    lst = it.in_last;
    case (shadow_mode)
      MODE_NORMAL: begin
        if (c != CH_BSLASH) begin
          emit_plain(c, lst);
        end else if (lst) begin
          raise_error(ERR_END, lst);
        end else begin
          shadow_mode = MODE_ESCAPE;
        end
      end
      MODE_ESCAPE: begin
        case (c)
          CH_QUOTE, CH_BSLASH, CH_SLASH: emit_plain(c, lst);
          CH_B: emit_plain(CTL_BS, lst);
          CH_F: emit_plain(CTL_FF, lst);
          CH_N: emit_plain(CTL_LF, lst);
          CH_R: emit_plain(CTL_CR, lst);
          CH_T: emit_plain(CTL_HT, lst);
          CH_U: begin
            if (lst) begin
              raise_error(ERR_END, lst);
            end else begin
              shadow_mode = MODE_HEX1;
              shadow_acc  = '0;
            end
          end
          default: raise_error(ERR_LETTER, lst);
        endcase
      end
      MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
        hv = hex_digit(c);
        cp = {shadow_acc[11:0], hv[3:0]};
        if (!hv[4]) begin
          raise_error(ERR_HEX, lst);
        end else if (shadow_mode != MODE_HEX4) begin
          // Only the fourth digit may close the string without an error.
          if (lst) begin
            raise_error(ERR_END, lst);
          end else begin
            shadow_acc  = cp;
            shadow_mode = shadow_mode + 3'd1;
          end
        end else begin
          shadow_mode = MODE_NORMAL;
          shadow_acc  = '0;
          if (cp < 16'h0080) begin
            expect_result(cp[7:0], 1'b1, ERR_NONE, 1'b1, lst);
          end else if (cp <= 16'h07FF) begin
            expect_result({3'b110, cp[10:6]}, 1'b1, ERR_NONE, 1'b0, 1'b0);
            expect_result({2'b10, cp[5:0]}, 1'b1, ERR_NONE, 1'b1, lst);
          end else begin
            expect_result({4'b1110, cp[15:12]}, 1'b1, ERR_NONE, 1'b0, 1'b0);
            expect_result({2'b10, cp[11:6]}, 1'b1, ERR_NONE, 1'b0, 1'b0);
            expect_result({2'b10, cp[5:0]}, 1'b1, ERR_NONE, 1'b1, lst);
          end
        end
      end
      default: begin
        // Discard mode swallows everything up to and including the final byte.
        if (lst) begin
          shadow_mode = MODE_NORMAL;
          shadow_acc  = '0;
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // String construction
  // --------------------------------------------------------------------------

  task automatic put(input logic [7:0] b);
    string_buf.push_back(b);
  endtask

  // Appends a \u escape with the leading ndig hex digits of cp, each letter
  // digit in a random case.
  task automatic put_unicode(input logic [15:0] cp, input int ndig);
    logic [3:0] nib;
    put(CH_BSLASH);
    put(CH_U);
    for (int k = 0; k < ndig; k++) begin
      nib = 4'(cp >> (12 - 4 * k));
      if (nib < 4'd10) begin
        put(8'h30 + 8'(nib));
      end else begin
        put(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10);
      end
    end
  endtask

  // Moves the built string to the input queue, marking its final byte.
  task automatic close_string();
    in_item_t it;
    for (int i = 0; i < string_buf.size(); i++) begin
      it.in_byte = string_buf[i];
      it.in_last = (i == string_buf.size() - 1);
      escaped_in_q.push_back(it);
    end
    items_queued += string_buf.size();
    string_buf.delete();
  endtask

  // Mostly well-formed strings with random content; about one segment in
  // seven is broken: a forbidden letter, a bad hex digit, or an early end.
  task automatic add_random_string();
    int          nseg;
    int          kind;
    logic [7:0]  b;
    logic [15:0] cp;
    logic        clash;
    logic        stop;
    nseg = $urandom_range(1, 6);
    stop = 1'b0;
    for (int i = 0; i < nseg && !stop; i++) begin
      kind = $urandom_range(0, 19);
      case ($urandom_range(0, 3))
        0: cp = 16'($urandom_range(16'h0000, 16'h007F));
        1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
        2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
        default: begin
          case ($urandom_range(0, 7))
            0: cp = 16'h0000;
            1: cp = 16'h007F;
            2: cp = 16'h0080;
            3: cp = 16'h07FF;
            4: cp = 16'h0800;
            5: cp = 16'hD800;
            6: cp = 16'hDFFF;
            default: cp = 16'hFFFF;
          endcase
        end
      endcase
      if (kind < 8) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
        put(b);
      end else if (kind < 11) begin
        put(CH_BSLASH);
        put(simple_esc[$urandom_range(0, 7)]);
      end else if (kind < 17) begin
        put_unicode(cp, 4);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            // Forbidden escape letter; the rest of the string is discarded.
            do begin
              b = 8'($urandom_range(0, 255));
              clash = (b == CH_U);
              foreach (simple_esc[j]) if (b == simple_esc[j]) clash = 1'b1;
            end while (clash);
            put(CH_BSLASH);
            put(b);
          end
          1: begin
            // A non-hex byte in place of one of the four digits.
            put_unicode(cp, $urandom_range(0, 3));
            do b = 8'($urandom_range(0, 255)); while (hex_digit(b) != 5'd0);
            put(b);
          end
          2: begin
            put_unicode(cp, $urandom_range(0, 3));
            stop = 1'b1;
          end
          default: begin
            put(CH_BSLASH);
            stop = 1'b1;
          end
        endcase
      end
    end
    close_string();
  endtask

  task automatic fill_random(input int unsigned n);
    int unsigned start;
    start = items_queued;
    while (items_queued - start < n) add_random_string();
  endtask

  task automatic wait_drained();
    while (escaped_in_q.size() != 0 || in_valid || utf8_expected_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d field %s: got 0x%0h, want 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver
  // --------------------------------------------------------------------------
  // A transfer in happens at an edge where in_valid is high and in_stall_o is
  // low; the shadow decoder sees it right then. A new item is only put up
  // once the previous one has gone, so a stalled payload never changes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall_o) begin
        decode_escaped_byte(in_data);
        items_accepted++;
      end
      if (!in_valid || !in_stall_o) begin
        if (escaped_in_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= escaped_in_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall
  // --------------------------------------------------------------------------
  // Once armed, the receiver holds off for a long stretch so the result
  // register fills and the block has to stall its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      hold_count <= 0;
    end else if (hold_armed && hold_count < HOLD_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor
  // --------------------------------------------------------------------------
  // Every result transfer is compared field by field with the oldest
  // prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (utf8_expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing predicted (byte 0x%0h)",
                                  results_seen, out_data_o.out_byte));
      end else begin
        oldest_want = utf8_expected_q.pop_front();
        check_field("out_byte", 32'(out_data_o.out_byte), 32'(oldest_want.out_byte));
        check_field("byte_valid", 32'(out_data_o.byte_valid),
                    32'(oldest_want.byte_valid));
        check_field("error_code", 32'(out_data_o.error_code),
                    32'(oldest_want.error_code));
        check_field("run_last", 32'(out_data_o.run_last), 32'(oldest_want.run_last));
        check_field("string_end", 32'(out_data_o.string_end),
                    32'(oldest_want.string_end));
      end
      if (out_data_o.error_code != ERR_NONE) error_results++;
      if (out_data_o.string_end) strings_closed++;
      results_seen++;
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, utf8_expected_q.size());
      $display("json_string_unescape_utf8_core_tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed strings, no idling. First, every simple escape in one string.
    foreach (simple_esc[i]) begin
      put(CH_BSLASH);
      put(simple_esc[i]);
    end
    close_string();
    // The largest code point, giving a three-byte burst on the final byte.
    put_unicode(16'hFFFF, 4);
    close_string();
    // A string that ends right after its backslash.
    put(CH_BSLASH);
    close_string();
    // A forbidden escape letter on the final byte.
    put(CH_BSLASH);
    put(8'h71);
    close_string();
    // A bad hex digit on the final byte.
    put(CH_BSLASH);
    put(CH_U);
    put(8'h47);
    close_string();
    fill_random(30);
    wait_drained();

    // Sender mostly idle.
    @(negedge clk_i);
    send_idle_pct  = 86;
    recv_stall_pct = 0;
    fill_random(25);
    wait_drained();

    // Receiver mostly stalling.
    @(negedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 86;
    fill_random(25);
    wait_drained();

    // Light gaps on both sides.
    @(negedge clk_i);
    send_idle_pct  = 18;
    recv_stall_pct = 18;
    fill_random(30);
    wait_drained();

    // Back-pressure: the receiver holds off while the sender keeps offering.
    @(negedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_armed     = 1'b1;
    fill_random(25);
    wait_drained();

    // A result is registered straight from its transfer in, so a short wait is
    // enough to catch anything stray.
    repeat (10) @(negedge clk_i);

    $display("Covered %0d input transfers and %0d results (%0d errors, %0d closed strings)",
             items_accepted, results_seen, error_results, strings_closed);
    $display("under no-idle, sender-idle, receiver-stall, mixed and long-hold traffic.");
    if (mismatch_count == 0) begin
      $display("json_string_unescape_utf8_core_tb: PASS");
    end else begin
      $display("json_string_unescape_utf8_core_tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/jsu_pkg.sv
hdl/jsu_decode.sv
hdl/json_string_unescape_utf8_core.sv
tb/json_string_unescape_utf8_core_tb.sv
